// File: sv/bdd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the balanced digit decomposer.
// No dependencies; every other SystemVerilog file imports this package.
package bdd_pkg;

   localparam int COEF_W    = 64;
   localparam int VAL_W     = 64;
   localparam int IDX_W     = 4;
   localparam int DB_W      = 6;
   localparam int LC_W      = 5;
   localparam int OFS_W     = 9;
   localparam int CSR_AW    = 4;
   localparam int CSR_DW    = 32;
   localparam int POS_W     = 9;
   localparam int LIM_W     = 7;
   localparam int LSB_W     = 10;
   localparam int SPAN_W    = 11;
   localparam int Y_W       = 126;
   localparam int TORUS_LSB = 63;

   localparam logic [DB_W-1:0]        DB_RESET  = 6'd16;
   localparam logic [LC_W-1:0]        LC_RESET  = 5'd4;
   localparam logic signed [OFS_W-1:0] OFS_RESET = 9'sd0;

   typedef enum logic [1:0] {
      REG_DIGIT_BITS   = 2'd0,
      REG_LIMB_COUNT   = 2'd1,
      REG_SCALE_SHIFT  = 2'd2,
      REG_INTEGER_MODE = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [DB_W-1:0]         digit_bits;
      logic signed [OFS_W-1:0] scale_shift;
      logic                    integer_mode;
   } plan_cfg_type;

   typedef struct packed {
      logic              ready;
      logic              active;
      logic [DB_W-1:0]   kb;
      logic [DB_W-1:0]   k;
      logic [POS_W-1:0]  last;
      logic [POS_W-1:0]  pos0;
      logic [LIM_W-1:0]  lim;
      logic [VAL_W-1:0]  carry;
      logic [VAL_W-1:0]  dmask;
      logic [VAL_W-1:0]  top;
   } plan_type;

endpackage

// File: sv/bdd_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for coefficient requests and limb responses.
// Depends on bdd_pkg for field widths.
interface bdd_req_if import bdd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [COEF_W-1:0] coefficient;
   logic                     last_coefficient;

   modport source (output valid, output coefficient, output last_coefficient, input ready);
   modport sink (input valid, input coefficient, input last_coefficient, output ready);
endinterface

interface bdd_rsp_if import bdd_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [IDX_W-1:0]        limb_index;
   logic signed [VAL_W-1:0] limb_value;
   logic                    last_limb;
   logic                    end_of_polynomial;

   modport source (output valid, output limb_index, output limb_value, output last_limb,
                   output end_of_polynomial, input ready);
   modport sink (input valid, input limb_index, input limb_value, input last_limb,
                 input end_of_polynomial, output ready);
endinterface

// File: sv/bdd_plan.sv
`timescale 1ns / 1ps
// Setup sequencer: derives digit layout and carry mask from the configuration
// with a restoring divide and a doubling mask build. Depends on bdd_pkg.
module bdd_plan import bdd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  plan_cfg_type cfg,
   output plan_type     plan
);

   typedef enum logic [3:0] {
      ST_LOAD  = 4'b0001,
      ST_DIV   = 4'b0010,
      ST_MASK  = 4'b0100,
      ST_READY = 4'b1000
   } plan_state_type;

   localparam logic [3:0] DIV_LAST  = 4'(POS_W - 1);
   localparam logic [3:0] MASK_LAST = 4'd5;

   plan_state_type     state_ff, state_in;
   logic [3:0]         step_ff, step_in;
   logic [DB_W-1:0]    kb_ff, kb_in;
   logic               active_ff, active_in;
   logic [POS_W-1:0]   n_ff, n_in;
   logic [POS_W-1:0]   num_ff, num_in;
   logic [DB_W-1:0]    rem_ff, rem_in;
   logic [POS_W-1:0]   quo_ff, quo_in;
   logic [SPAN_W-1:0]  span_ff, span_in;
   logic [VAL_W-1:0]   mask_ff, mask_in;
   logic [VAL_W-1:0]   dmask_ff, dmask_in;

   logic [DB_W-1:0]         kb_eff;
   logic signed [LSB_W-1:0] lsb;
   logic [DB_W:0]           trial;
   logic [DB_W:0]           diff;
   logic                    ge;
   logic [DB_W-1:0]         rem_next;
   logic [DB_W-1:0]         kk;

   assign kb_eff   = (cfg.digit_bits == '0) ? DB_W'(1) : cfg.digit_bits;
   assign lsb      = cfg.integer_mode ? LSB_W'(cfg.scale_shift)
                                      : LSB_W'(cfg.scale_shift) + LSB_W'(TORUS_LSB);
   assign trial    = {rem_ff, num_ff[POS_W-1]};
   assign diff     = trial - {1'b0, kb_ff};
   assign ge       = trial >= {1'b0, kb_ff};
   assign rem_next = ge ? diff[DB_W-1:0] : trial[DB_W-1:0];
   assign kk       = kb_ff - DB_W'(1) - rem_ff;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      kb_in     = kb_ff;
      active_in = active_ff;
      n_in      = n_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      span_in   = span_ff;
      mask_in   = mask_ff;
      dmask_in  = dmask_ff;
      case (state_ff)
         ST_LOAD: begin
            kb_in     = kb_eff;
            active_in = lsb > 0;
            n_in      = (lsb > 0) ? POS_W'(lsb - 1) : '0;
            num_in    = (lsb > 0) ? POS_W'(lsb - 1) : '0;
            rem_in    = '0;
            quo_in    = '0;
            step_in   = '0;
            dmask_in  = ~({VAL_W{1'b1}} << kb_eff);
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = rem_next;
            quo_in  = {quo_ff[POS_W-2:0], ge};
            num_in  = {num_ff[POS_W-2:0], 1'b0};
            step_in = step_ff + 4'd1;
            if (step_ff == DIV_LAST) begin
               step_in  = '0;
               mask_in  = VAL_W'(1) << rem_next;
               span_in  = SPAN_W'(kb_ff);
               state_in = ST_MASK;
            end
         end
         ST_MASK: begin
            mask_in = mask_ff | (mask_ff << span_ff);
            span_in = span_ff << 1;
            step_in = step_ff + 4'd1;
            if (step_ff == MASK_LAST) begin
               state_in = ST_READY;
            end
         end
         ST_READY: begin
            state_in = ST_READY;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
      if (start) begin
         state_in = ST_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
      kb_ff     <= kb_in;
      active_ff <= active_in;
      n_ff      <= n_in;
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      span_ff   <= span_in;
      mask_ff   <= mask_in;
      dmask_ff  <= dmask_in;
   end

   assign plan.ready  = state_ff == ST_READY;
   assign plan.active = active_ff;
   assign plan.kb     = kb_ff;
   assign plan.k      = kk;
   assign plan.last   = quo_ff + POS_W'(1);
   assign plan.pos0   = n_ff - POS_W'(rem_ff);
   assign plan.lim    = LIM_W'(TORUS_LSB) + LIM_W'(kk);
   assign plan.carry  = mask_ff;
   assign plan.dmask  = dmask_ff;
   assign plan.top    = dmask_ff ^ (dmask_ff >> 1);

endmodule

// File: sv/balanced_digit_decompose.sv
`timescale 1ns / 1ps
// Balanced base-2^digit_bits decomposition of signed coefficients into limbs.
// Depends on bdd_pkg, bdd_if (bdd_req_if, bdd_rsp_if) and bdd_plan.
//
// Each accepted coefficient yields max(1, min(limb_count, MAX_LIMBS)) limb
// transactions, most significant limb first, one per cycle from the result
// register while rsp_chan.ready is high (4 limbs at the reset configuration, 1
// when limb_count is 1). A coefficient passes a magnitude register and a recode
// register before its limbs are sliced out into the result register. A new
// coefficient is taken while the previous one is still emitting. After reset and
// after every CSR write the setup sequencer runs a 9-step restoring divide,
// then a 6-step carry-mask build, and req_chan.ready stays low meanwhile; CSR
// writes are taken at all times. Registers: digit_bits at 0x0, limb_count at
// 0x4, scale_shift at 0x8, integer_mode at 0xC.
module balanced_digit_decompose import bdd_pkg::*; #(
   parameter int MAX_LIMBS = 16
) (
   input  logic              clock,
   input  logic              reset,
   bdd_req_if.sink           req_chan,
   bdd_rsp_if.source         rsp_chan,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int CNT_W = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1;

   logic [DB_W-1:0]         db_ff;
   logic [LC_W-1:0]         lc_ff;
   logic signed [OFS_W-1:0] ofs_ff;
   logic                    mode_ff;
   logic                    csr_write;
   reg_index_type           csr_index;

   plan_cfg_type plan_cfg;
   plan_type     plan;

   logic [CNT_W-1:0] nl_last;

   logic             s1_valid_ff, s1_valid_in;
   logic             s1_neg_ff;
   logic             s1_eop_ff;
   logic [VAL_W-1:0] s1_mag_ff;

   logic             s2_valid_ff, s2_valid_in;
   logic             s2_neg_ff;
   logic             s2_eop_ff;
   logic [Y_W-1:0]   s2_y_ff;
   logic [CNT_W-1:0] s2_limb_ff, s2_limb_in;
   logic [POS_W-1:0] s2_pos_ff, s2_pos_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] rsp_idx_ff;
   logic [VAL_W-1:0] rsp_val_ff;
   logic             rsp_last_ff;
   logic             rsp_eop_ff;

   logic             s1_take, s2_take, s2_done, rsp_load, s2_is_last;
   logic [VAL_W-1:0] halved, recoded;
   logic [Y_W-1:0]   y_in;
   logic [Y_W-1:0]   shifted;
   logic [VAL_W-1:0] raw, ext, limb_val;
   logic             in_range;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         db_ff   <= DB_RESET;
         lc_ff   <= LC_RESET;
         ofs_ff  <= OFS_RESET;
         mode_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            REG_DIGIT_BITS:   db_ff   <= csr_pwdata[DB_W-1:0];
            REG_LIMB_COUNT:   lc_ff   <= csr_pwdata[LC_W-1:0];
            REG_SCALE_SHIFT:  ofs_ff  <= csr_pwdata[OFS_W-1:0];
            REG_INTEGER_MODE: mode_ff <= csr_pwdata[0];
            default: begin
               db_ff <= db_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_DIGIT_BITS:   csr_prdata = CSR_DW'(db_ff);
         REG_LIMB_COUNT:   csr_prdata = CSR_DW'(lc_ff);
         REG_SCALE_SHIFT:  csr_prdata = CSR_DW'(ofs_ff);
         REG_INTEGER_MODE: csr_prdata = CSR_DW'(mode_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign plan_cfg.digit_bits   = db_ff;
   assign plan_cfg.scale_shift  = ofs_ff;
   assign plan_cfg.integer_mode = mode_ff;

   bdd_plan u_plan (
      .clock (clock),
      .reset (reset),
      .start (csr_write),
      .cfg   (plan_cfg),
      .plan  (plan)
   );

   always_comb begin
      if (lc_ff == '0) begin
         nl_last = '0;
      end else if (int'(lc_ff) > MAX_LIMBS) begin
         nl_last = CNT_W'(MAX_LIMBS - 1);
      end else begin
         nl_last = CNT_W'(lc_ff - LC_W'(1));
      end
   end

   // Handshake and stage movement
   assign rsp_load   = !rsp_valid_ff || rsp_chan.ready;
   assign s2_is_last = s2_limb_ff == nl_last;
   assign s2_done    = s2_valid_ff && rsp_load && s2_is_last;
   assign s2_take    = s1_valid_ff && (!s2_valid_ff || s2_done);
   assign req_chan.ready = plan.ready && (!s1_valid_ff || s2_take);
   assign s1_take    = req_chan.valid && req_chan.ready;

   assign s1_valid_in  = s1_take ? 1'b1 : (s2_take ? 1'b0 : s1_valid_ff);
   assign s2_valid_in  = s2_take ? 1'b1 : (s2_done ? 1'b0 : s2_valid_ff);
   assign rsp_valid_in = rsp_load ? s2_valid_ff : rsp_valid_ff;

   // Recode: halve in torus mode, then add and xor the carry mask
   assign halved  = plan_cfg.integer_mode ? s1_mag_ff : (s1_mag_ff >> 1);
   assign recoded = (halved + plan.carry) ^ plan.carry;
   assign y_in    = Y_W'(recoded) << plan.k;

   always_comb begin
      s2_limb_in = s2_limb_ff;
      s2_pos_in  = s2_pos_ff;
      if (s2_take) begin
         s2_limb_in = '0;
         s2_pos_in  = plan.pos0;
      end else if (s2_valid_ff && rsp_load) begin
         s2_limb_in = s2_limb_ff + CNT_W'(1);
         s2_pos_in  = s2_pos_ff - POS_W'(plan.kb);
      end
   end

   // Slice the current limb
   assign shifted  = s2_y_ff >> s2_pos_ff[LIM_W-1:0];
   assign raw      = shifted[VAL_W-1:0] & plan.dmask;
   assign ext      = (|(raw & plan.top)) ? (raw | ~plan.dmask) : raw;
   assign in_range = plan.active && (POS_W'(s2_limb_ff) < plan.last)
                     && (POS_W'(plan.lim) > s2_pos_ff);
   assign limb_val = in_range ? (s2_neg_ff ? -ext : ext) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         s2_limb_ff   <= '0;
         s2_pos_ff    <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         s2_limb_ff   <= s2_limb_in;
         s2_pos_ff    <= s2_pos_in;
      end
      if (s1_take) begin
         s1_neg_ff <= req_chan.coefficient[COEF_W-1];
         s1_mag_ff <= req_chan.coefficient[COEF_W-1] ? VAL_W'(-req_chan.coefficient)
                                                     : VAL_W'(req_chan.coefficient);
         s1_eop_ff <= req_chan.last_coefficient;
      end
      if (s2_take) begin
         s2_neg_ff <= s1_neg_ff;
         s2_eop_ff <= s1_eop_ff;
         s2_y_ff   <= y_in;
      end
      if (rsp_load && s2_valid_ff) begin
         rsp_idx_ff  <= IDX_W'(s2_limb_ff);
         rsp_val_ff  <= limb_val;
         rsp_last_ff <= s2_is_last;
         rsp_eop_ff  <= s2_is_last && s2_eop_ff;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.limb_index        = rsp_idx_ff;
   assign rsp_chan.limb_value        = rsp_val_ff;
   assign rsp_chan.last_limb         = rsp_last_ff;
   assign rsp_chan.end_of_polynomial = rsp_eop_ff;

   a_cfg_write_blocks_req: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> !req_chan.ready)
      else $error("request accepted while setup sequencer restarts");

   a_req_lands_in_s1: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> s1_valid_ff)
      else $error("accepted transaction lost before magnitude stage");

   a_limbs_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !rsp_chan.last_limb) |=> rsp_chan.valid)
      else $error("gap between limbs of one coefficient");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for balanced_digit_decompose: random and directed coefficients under
// many digit/limb/shift settings, limbs compared against an in-bench decomposition.
// Depends on bdd_pkg, bdd_if and the balanced_digit_decompose RTL.
module testbench;
   import bdd_pkg::*;

   localparam int MAX_LIMBS = 16;

   typedef struct {
      logic [COEF_W-1:0] coefficient;
      logic              last_coefficient;
   } coef_item_type;

   typedef struct {
      logic [IDX_W-1:0] limb_index;
      logic [VAL_W-1:0] limb_value;
      logic             last_limb;
      logic             end_of_polynomial;
   } limb_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic [COEF_W-1:0] req_coef = '0;
   logic              req_last = 1'b0;
   logic              rsp_ready = 1'b0;

   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   logic [DB_W-1:0]         cfg_digit_bits = DB_RESET;
   logic [LC_W-1:0]         cfg_limb_count = LC_RESET;
   logic signed [OFS_W-1:0] cfg_scale_shift = OFS_RESET;
   logic                    cfg_integer_mode = 1'b0;

   coef_item_type coef_queue[$];
   limb_type      expected_limbs[$];
   coef_item_type next_item;
   limb_type      got_limb;
   limb_type      want_limb;
   logic       quiet = 1'b0;
   int         req_wait = 0;
   int         rsp_wait = 0;
   int         rsp_stall;
   int         error_count = 0;

   bdd_req_if req_bus ();
   bdd_rsp_if rsp_bus ();

   assign req_bus.valid = req_valid;
   assign req_bus.coefficient = req_coef;
   assign req_bus.last_coefficient = req_last;
   assign rsp_bus.ready = rsp_ready;

   balanced_digit_decompose #(.MAX_LIMBS(MAX_LIMBS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   function automatic int draw_wait();
      return quiet ? 0 : int'($urandom_range(0, 10));
   endfunction

   function automatic void predict_limbs(input logic [COEF_W-1:0] coef, input logic last_coef);
      logic [VAL_W-1:0] digits [MAX_LIMBS];
      logic [VAL_W-1:0] mag;
      logic [VAL_W-1:0] carry;
      logic [VAL_W-1:0] dmask;
      logic [VAL_W-1:0] d;
      logic             neg;
      int               kb, nl, lsb, last, k, lo, hi, i, j;
      limb_type         e;
      kb = (cfg_digit_bits == 0) ? 1 : int'(cfg_digit_bits);
      nl = (cfg_limb_count == 0) ? 1 : int'(cfg_limb_count);
      if (nl > MAX_LIMBS) nl = MAX_LIMBS;
      neg = coef[COEF_W-1];
      mag = neg ? 64'd0 - coef : coef;
      for (j = 0; j < MAX_LIMBS; j++) digits[j] = '0;
      if (cfg_integer_mode) begin
         lsb = int'(cfg_scale_shift);
      end else begin
         mag = mag >> 1;
         lsb = TORUS_LSB + int'(cfg_scale_shift);
      end
      if (lsb > 0) begin
         last = (lsb + kb - 1) / kb;
         k = last * kb - lsb;
         carry = '0;
         dmask = (64'd1 << kb) - 64'd1;
         lo = (last - nl < 0) ? 0 : last - nl;
         hi = (63 + k + kb - 1) / kb;
         if (hi > last) hi = last;
         for (i = 1; i * kb - 1 - k < 64; i++) carry = carry + (64'd1 << (i * kb - 1 - k));
         mag = (mag + carry) ^ carry;
         for (i = lo; i < hi; i++) begin
            if (i == 0) d = (mag << k) & dmask;
            else d = (mag >> (i * kb - k)) & dmask;
            if (d[kb-1]) d = d | ~dmask;
            if (neg) d = 64'd0 - d;
            digits[last - 1 - i] = d;
         end
      end
      for (j = 0; j < nl; j++) begin
         e.limb_index = j[IDX_W-1:0];
         e.limb_value = digits[j];
         e.last_limb = (j == nl - 1);
         e.end_of_polynomial = (j == nl - 1) && last_coef;
         expected_limbs.push_back(e);
      end
   endfunction

   function automatic logic [COEF_W-1:0] rand_coef();
      logic [COEF_W-1:0] c;
      case ($urandom_range(0, 3))
         0: c = 64'($urandom_range(0, 1000));
         1: c = (64'd1 << $urandom_range(0, 63)) + 64'($urandom_range(0, 2)) - 64'd1;
         default: c = {$urandom, $urandom};
      endcase
      if ($urandom_range(0, 1)) c = 64'd0 - c;
      return c;
   endfunction

   task automatic push_coef(input logic [COEF_W-1:0] c, input logic l);
      coef_item_type it;
      it.coefficient = c;
      it.last_coefficient = l;
      coef_queue.push_back(it);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (coef_queue.size() != 0 || req_valid || expected_limbs.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [CSR_DW-1:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_DIGIT_BITS:   cfg_digit_bits = data[DB_W-1:0];
         REG_LIMB_COUNT:   cfg_limb_count = data[LC_W-1:0];
         REG_SCALE_SHIFT:  cfg_scale_shift = data[OFS_W-1:0];
         REG_INTEGER_MODE: cfg_integer_mode = data[0];
         default: ;
      endcase
   endtask

   task automatic apply_config(input int db, input int lc, input int ofs, input int im);
      logic [CSR_DW-1:0] data;
      wait_idle();
      data = $urandom;
      data[DB_W-1:0] = db[DB_W-1:0];
      csr_write(REG_DIGIT_BITS, data);
      data = $urandom;
      data[LC_W-1:0] = lc[LC_W-1:0];
      csr_write(REG_LIMB_COUNT, data);
      data = $urandom;
      data[OFS_W-1:0] = ofs[OFS_W-1:0];
      csr_write(REG_SCALE_SHIFT, data);
      data = $urandom;
      data[0] = im[0];
      csr_write(REG_INTEGER_MODE, data);
      quiet = ($urandom_range(0, 2) == 0);
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   // Driver: hold each transaction until accepted, predict its limbs at acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_wait <= 0;
      end else begin
         if (req_valid && req_bus.ready) predict_limbs(req_coef, req_last);
         if (!req_valid || req_bus.ready) begin
            if (req_wait > 0) begin
               req_wait <= req_wait - 1;
               req_valid <= 1'b0;
            end else if (coef_queue.size() > 0) begin
               next_item = coef_queue.pop_front();
               req_coef <= next_item.coefficient;
               req_last <= next_item.last_coefficient;
               req_valid <= 1'b1;
               req_wait <= draw_wait();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each limb transaction with the oldest expected limb.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait <= 0;
      end else if (rsp_ready && rsp_bus.valid) begin
         got_limb.limb_index = rsp_bus.limb_index;
         got_limb.limb_value = rsp_bus.limb_value;
         got_limb.last_limb = rsp_bus.last_limb;
         got_limb.end_of_polynomial = rsp_bus.end_of_polynomial;
         if (expected_limbs.size() == 0) begin
            $display("%0t unexpected limb: idx %0d value %h last %b eop %b", $time,
                     got_limb.limb_index, got_limb.limb_value, got_limb.last_limb,
                     got_limb.end_of_polynomial);
            error_count++;
         end else begin
            want_limb = expected_limbs.pop_front();
            if (got_limb.limb_index !== want_limb.limb_index ||
                got_limb.limb_value !== want_limb.limb_value ||
                got_limb.last_limb !== want_limb.last_limb ||
                got_limb.end_of_polynomial !== want_limb.end_of_polynomial) begin
               $display("%0t limb mismatch: expected %0d %h %b %b, got %0d %h %b %b",
                        $time, want_limb.limb_index, want_limb.limb_value,
                        want_limb.last_limb, want_limb.end_of_polynomial,
                        got_limb.limb_index, got_limb.limb_value, got_limb.last_limb,
                        got_limb.end_of_polynomial);
               error_count++;
            end
         end
         rsp_stall = draw_wait();
         rsp_ready <= (rsp_stall == 0);
         rsp_wait <= rsp_stall;
      end else if (rsp_wait > 0) begin
         rsp_wait <= rsp_wait - 1;
         rsp_ready <= (rsp_wait == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      int random_count;
      int n, db, lc, ofs, im, i;
      random_count = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      push_coef(64'd0, 1'b0);
      push_coef(64'd1, 1'b1);
      push_coef(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      push_coef(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
      push_coef(64'h8000_0000_0000_0000, 1'b1);
      push_coef(64'h4000_0000_0000_0000, 1'b0);
      push_coef(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      push_coef(64'h5555_5555_5555_5555, 1'b1);

      apply_config(0, 31, 10, 1);
      push_coef(64'h8000_0000_0000_0000, 1'b0);
      push_coef(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
      push_coef(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);

      apply_config(63, 1, 0, 0);
      push_coef(64'h8000_0000_0000_0000, 1'b1);
      push_coef(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);

      apply_config(1, 16, -64, 0);
      push_coef(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
      push_coef(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);

      apply_config(7, 16, 255, 1);
      push_coef(64'h0123_4567_89AB_CDEF, 1'b1);

      apply_config(16, 0, -63, 0);
      push_coef(64'h8000_0000_0000_0001, 1'b1);

      apply_config(5, 13, 1, 1);
      push_coef(64'd1, 1'b0);
      push_coef(64'h8000_0000_0000_0000, 1'b1);

      while (random_count < 130) begin
         case ($urandom_range(0, 15))
            0: db = 0;
            1, 2, 3, 4, 5, 6, 7: db = $urandom_range(1, 16);
            default: db = $urandom_range(1, 63);
         endcase
         case ($urandom_range(0, 9))
            0: lc = 0;
            1: lc = $urandom_range(17, 31);
            default: lc = $urandom_range(1, 16);
         endcase
         im = $urandom_range(0, 1);
         if ($urandom_range(0, 3) == 0) ofs = int'($urandom_range(0, 319)) - 64;
         else if (im != 0) ofs = $urandom_range(1, 120);
         else ofs = int'($urandom_range(0, 60)) - 50;
         apply_config(db, lc, ofs, im);
         n = $urandom_range(6, 20);
         for (i = 0; i < n; i++) push_coef(rand_coef(), $urandom_range(0, 1));
         random_count += n;
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (error_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

// File: sim.f
sv/bdd_pkg.sv
sv/bdd_if.sv
sv/bdd_plan.sv
sv/balanced_digit_decompose.sv
sim/testbench.sv
